// ===== src/gspd_pkg.sv =====
// shared types, constants and microcode table for the gain-scheduled pd controller
package gspd_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_MODE_STATIC = 3'd0;
	localparam logic [2:0] REG_STATIC_KP   = 3'd1;
	localparam logic [2:0] REG_STATIC_KD   = 3'd2;
	localparam logic [2:0] REG_DYN_KP_BASE = 3'd3;
	localparam logic [2:0] REG_DYN_KD      = 3'd4;
	localparam logic [2:0] REG_INV_SCALE   = 3'd5;

	// register reset values
	localparam logic [15:0] RST_STATIC_KP   = 16'd1792;
	localparam logic [15:0] RST_STATIC_KD   = 16'd10240;
	localparam logic [15:0] RST_DYN_KP_BASE = 16'd1280;
	localparam logic [15:0] RST_DYN_KD      = 16'd7680;
	localparam logic [15:0] RST_INV_SCALE   = 16'd15604;

	// radicand u << 8 stays below 2^27; its root never needs more than 14 bits
	localparam int RAD_W  = 27;
	localparam int ROOT_W = 14;

	typedef logic [3:0] step_t;

	// program addresses
	localparam step_t STEP_IDLE    = 4'd0;
	localparam step_t STEP_AINV    = 4'd1;
	localparam step_t STEP_LOAD_U  = 4'd2;
	localparam step_t STEP_ROOT    = 4'd3;
	localparam step_t STEP_US      = 4'd4;
	localparam step_t STEP_KP_DYN  = 4'd5;
	localparam step_t STEP_KP_STAT = 4'd6;
	localparam step_t STEP_KPE     = 4'd7;
	localparam step_t STEP_KDD     = 4'd8;
	localparam step_t STEP_EMIT    = 4'd9;

	// datapath action of a control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_AINV,
		OP_LOAD_U,
		OP_ROOT,
		OP_MUL_US,
		OP_KP_DYN,
		OP_KP_STAT,
		OP_MUL_KPE,
		OP_MUL_KDD,
		OP_EMIT
	} op_t;

	// sequencing condition of a control word
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_GOTO,
		JC_ACCEPT,
		JC_LOOP,
		JC_OUT
	} jcond_t;

	typedef struct packed {
		op_t    op;
		jcond_t cond;
		step_t  target;
	} ctl_word_t;

	// control store
	function automatic ctl_word_t ucode(input step_t step);
		ctl_word_t cw;
		case (step)
			STEP_IDLE:    cw = '{op: OP_LOAD,     cond: JC_ACCEPT, target: STEP_KP_STAT};
			STEP_AINV:    cw = '{op: OP_MUL_AINV, cond: JC_NEXT,   target: STEP_IDLE};
			STEP_LOAD_U:  cw = '{op: OP_LOAD_U,   cond: JC_NEXT,   target: STEP_IDLE};
			STEP_ROOT:    cw = '{op: OP_ROOT,     cond: JC_LOOP,   target: STEP_IDLE};
			STEP_US:      cw = '{op: OP_MUL_US,   cond: JC_NEXT,   target: STEP_IDLE};
			STEP_KP_DYN:  cw = '{op: OP_KP_DYN,   cond: JC_GOTO,   target: STEP_KPE};
			STEP_KP_STAT: cw = '{op: OP_KP_STAT,  cond: JC_NEXT,   target: STEP_IDLE};
			STEP_KPE:     cw = '{op: OP_MUL_KPE,  cond: JC_NEXT,   target: STEP_IDLE};
			STEP_KDD:     cw = '{op: OP_MUL_KDD,  cond: JC_NEXT,   target: STEP_IDLE};
			STEP_EMIT:    cw = '{op: OP_EMIT,     cond: JC_OUT,    target: STEP_IDLE};
			default:      cw = '{op: OP_NOP,      cond: JC_GOTO,   target: STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

// ===== src/gain_scheduled_pd_controller.sv =====
// microcoded gain-scheduled pd controller: top level
//
//  channel   signals                                   direction  transfer
//  sample    sample_valid, sample_stall, error_sample  in         valid & !stall
//  result    result_valid, result_stall, drive, kp_used out       valid & !stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         valid & ready
//
// dynamic mode: a square root loop decides one root bit per cycle on a shared
// subtractor. one shared 20x18 multiplier serves all products.
// arst_n clears the sequencer, the output valid, prev_error and the configuration registers.
// a new item is taken while a result still waits; only the emit step waits on
// result_stall. cfg_ready is always high.
module gain_scheduled_pd_controller #(
	parameter int SQRT_ITERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] error_sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] drive,
	output logic        [15:0] kp_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	localparam int CNT_W = $clog2(SQRT_ITERS);
	localparam int TW    = 2 * SQRT_ITERS + 1;
	localparam int CW    = (TW > gspd_pkg::RAD_W) ? TW : gspd_pkg::RAD_W;
	localparam int RX    = (SQRT_ITERS > gspd_pkg::ROOT_W) ? SQRT_ITERS : gspd_pkg::ROOT_W;

	// configuration registers
	logic        mode_static_q;
	logic [15:0] static_kp_q;
	logic [15:0] static_kd_q;
	logic [15:0] dyn_kp_base_q;
	logic [15:0] dyn_kd_q;
	logic [15:0] inv_scale_q;

	// sequencer
	gspd_pkg::step_t     step_q;
	gspd_pkg::step_t     step_d;
	gspd_pkg::ctl_word_t cw;

	// datapath
	logic signed [15:0]       e_q;
	logic signed [15:0]       prev_q;
	logic [18:0]              u_q;
	logic [gspd_pkg::RAD_W-1:0] rem_q;
	logic [SQRT_ITERS-1:0]    r_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [15:0]              kp_q;
	logic [15:0]              kd_q;
	logic signed [37:0]       mul_q;
	logic signed [34:0]       acc_q;
	logic signed [31:0]       drive_q;
	logic [15:0]              kp_used_q;
	logic                     result_valid_q;

	logic                     sample_fire;
	logic                     out_free;
	logic                     do_emit;
	logic [16:0]              e_mag;
	logic signed [16:0]       diff;
	logic signed [19:0]       mul_a;
	logic signed [17:0]       mul_b;
	logic [CW-1:0]            term;
	logic                     root_keep;
	logic [gspd_pkg::RAD_W-1:0] rem_next;
	logic [RX-1:0]            r_wide;
	logic [gspd_pkg::ROOT_W-1:0] root_s;
	logic [25:0]              kp_sum;
	logic [15:0]              kp_dyn;
	logic signed [34:0]       pd_sum;
	logic [SQRT_ITERS-1:0]    low_mask;

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign drive        = drive_q;
	assign kp_used      = kp_used_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_static_q <= 1'b0;
			static_kp_q   <= gspd_pkg::RST_STATIC_KP;
			static_kd_q   <= gspd_pkg::RST_STATIC_KD;
			dyn_kp_base_q <= gspd_pkg::RST_DYN_KP_BASE;
			dyn_kd_q      <= gspd_pkg::RST_DYN_KD;
			inv_scale_q   <= gspd_pkg::RST_INV_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gspd_pkg::REG_MODE_STATIC: mode_static_q <= cfg_data[0];
				gspd_pkg::REG_STATIC_KP:   static_kp_q   <= cfg_data;
				gspd_pkg::REG_STATIC_KD:   static_kd_q   <= cfg_data;
				gspd_pkg::REG_DYN_KP_BASE: dyn_kp_base_q <= cfg_data;
				gspd_pkg::REG_DYN_KD:      dyn_kd_q      <= cfg_data;
				gspd_pkg::REG_INV_SCALE:   inv_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// control word fetch and handshake decode
	always_comb begin
		cw           = gspd_pkg::ucode(step_q);
		sample_stall = (cw.cond != gspd_pkg::JC_ACCEPT);
		sample_fire  = sample_valid && !sample_stall;
		out_free     = !result_valid_q || !result_stall;
		do_emit      = (cw.op == gspd_pkg::OP_EMIT) && out_free;
	end

	// next step
	always_comb begin
		case (cw.cond)
			gspd_pkg::JC_NEXT:   step_d = step_q + 4'd1;
			gspd_pkg::JC_GOTO:   step_d = cw.target;
			gspd_pkg::JC_ACCEPT: begin
				if (!sample_fire)
					step_d = step_q;
				else if (mode_static_q)
					step_d = cw.target;
				else
					step_d = step_q + 4'd1;
			end
			gspd_pkg::JC_LOOP:   step_d = (cnt_q == '0) ? step_q + 4'd1 : step_q;
			gspd_pkg::JC_OUT:    step_d = out_free ? cw.target : step_q;
			default:             step_d = gspd_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= gspd_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		e_mag = e_q[15] ? 17'd0 - {e_q[15], e_q} : {e_q[15], e_q};
		diff  = {e_q[15], e_q} - {prev_q[15], prev_q};
		r_wide = RX'(r_q);
		root_s = r_wide[gspd_pkg::ROOT_W-1:0];
		case (cw.op)
			gspd_pkg::OP_MUL_AINV: begin
				mul_a = {3'b000, e_mag};
				mul_b = {2'b00, inv_scale_q};
			end
			gspd_pkg::OP_MUL_US: begin
				mul_a = {1'b0, u_q};
				mul_b = {4'b0000, root_s};
			end
			gspd_pkg::OP_MUL_KPE: begin
				mul_a = {4'b0000, kp_q};
				mul_b = {{2{e_q[15]}}, e_q};
			end
			gspd_pkg::OP_MUL_KDD: begin
				mul_a = {4'b0000, kd_q};
				mul_b = {diff[16], diff};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// one root bit: keep it when (r << (i+1)) + 4^i fits in the remainder
	always_comb begin
		term      = (CW'(r_q) << ({1'b0, cnt_q} + 1'b1)) | (CW'(1) << {cnt_q, 1'b0});
		root_keep = term <= CW'(rem_q);
		rem_next  = gspd_pkg::RAD_W'(CW'(rem_q) - term);
		low_mask  = (SQRT_ITERS'(2) << cnt_q) - SQRT_ITERS'(1);
	end

	// gain sum with saturation, and the pd sum reduced to q.4
	always_comb begin
		kp_sum = 26'(mul_q[32:8]) + 26'(dyn_kp_base_q);
		kp_dyn = (kp_sum[25:16] != '0) ? 16'hffff : kp_sum[15:0];
		pd_sum = acc_q + $signed(mul_q[34:0]);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (cw.op)
			gspd_pkg::OP_LOAD: begin
				if (sample_fire)
					e_q <= error_sample;
			end
			gspd_pkg::OP_MUL_AINV: mul_q <= mul_a * mul_b;
			gspd_pkg::OP_LOAD_U: begin
				u_q   <= mul_q[30:12];
				rem_q <= {mul_q[30:12], 8'b0};
				r_q   <= '0;
				cnt_q <= CNT_W'(SQRT_ITERS - 1);
			end
			gspd_pkg::OP_ROOT: begin
				if (root_keep) begin
					r_q   <= r_q | (SQRT_ITERS'(1) << cnt_q);
					rem_q <= rem_next;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			gspd_pkg::OP_MUL_US: mul_q <= mul_a * mul_b;
			gspd_pkg::OP_KP_DYN: begin
				kp_q <= kp_dyn;
				kd_q <= dyn_kd_q;
			end
			gspd_pkg::OP_KP_STAT: begin
				kp_q <= static_kp_q;
				kd_q <= static_kd_q;
			end
			gspd_pkg::OP_MUL_KPE: mul_q <= mul_a * mul_b;
			gspd_pkg::OP_MUL_KDD: begin
				acc_q <= $signed(mul_q[34:0]);
				mul_q <= mul_a * mul_b;
			end
			gspd_pkg::OP_EMIT: begin
				if (out_free) begin
					drive_q   <= {{5{pd_sum[34]}}, pd_sum[34:8]};
					kp_used_q <= kp_q;
				end
			end
			default: ;
		endcase
	end

	// previous sample and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (do_emit) begin
				prev_q         <= e_q;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// a result appears only out of the emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(step_q) == gspd_pkg::STEP_EMIT)
		else $error("result raised outside emit step");

	// an accepted item always starts the program
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_fire |=> step_q != gspd_pkg::STEP_IDLE)
		else $error("accepted item did not start the program");

	// the reduced pd sum never reaches the 32-bit limits
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (drive_q[31:26] == 6'h00 || drive_q[31:26] == 6'h3f))
		else $error("drive outside the reachable range");

	// root bits at and below the current position are still undecided
	assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == gspd_pkg::OP_ROOT) |-> (r_q & low_mask) == '0)
		else $error("root bit set ahead of the loop");

endmodule
